/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion helpers. Each one reports through $error only.

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/wbcl_pkg.sv */
package wbcl_pkg;

    localparam int WBCL_LINES  = 256;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WRITEBACK_CLEAN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INCLUSIVE       = 1'b1;

    localparam logic [3:0] REQ_GETS      = 4'd0;
    localparam logic [3:0] REQ_GETX      = 4'd1;
    localparam logic [3:0] REQ_GETSEX    = 4'd2;
    localparam logic [3:0] REQ_PUTE      = 4'd3;
    localparam logic [3:0] REQ_PUTM      = 4'd4;
    localparam logic [3:0] REQ_FLUSH     = 4'd5;
    localparam logic [3:0] REQ_FLUSHINV  = 4'd6;
    localparam logic [3:0] REQ_GETSRESP  = 4'd7;
    localparam logic [3:0] REQ_GETXRESP  = 4'd8;
    localparam logic [3:0] REQ_FLUSHRESP = 4'd9;
    localparam logic [3:0] REQ_EVICT     = 4'd10;

    localparam logic [2:0] PEND_NONE     = 3'd0;
    localparam logic [2:0] PEND_GETS     = 3'd1;
    localparam logic [2:0] PEND_GETX     = 3'd2;
    localparam logic [2:0] PEND_FLUSH    = 3'd3;
    localparam logic [2:0] PEND_FLUSHINV = 3'd4;

    localparam logic [1:0] ACT_DONE  = 2'd0;
    localparam logic [1:0] ACT_STALL = 2'd1;
    localparam logic [1:0] ACT_BLOCK = 2'd2;
    localparam logic [1:0] ACT_ERROR = 2'd3;

    localparam logic [2:0] DOWN_NONE     = 3'd0;
    localparam logic [2:0] DOWN_GETS     = 3'd1;
    localparam logic [2:0] DOWN_GETX     = 3'd2;
    localparam logic [2:0] DOWN_GETSEX   = 3'd3;
    localparam logic [2:0] DOWN_PUTE     = 3'd4;
    localparam logic [2:0] DOWN_PUTM     = 3'd5;
    localparam logic [2:0] DOWN_FLUSH    = 3'd6;
    localparam logic [2:0] DOWN_FLUSHINV = 3'd7;

    localparam logic [1:0] UP_NONE   = 2'd0;
    localparam logic [1:0] UP_DATA_E = 2'd1;
    localparam logic [1:0] UP_DATA_M = 2'd2;
    localparam logic [1:0] UP_FLUSH  = 2'd3;

    localparam logic [2:0] ST_I  = 3'd0;
    localparam logic [2:0] ST_E  = 3'd1;
    localparam logic [2:0] ST_M  = 3'd2;
    localparam logic [2:0] ST_IS = 3'd3;
    localparam logic [2:0] ST_IM = 3'd4;
    localparam logic [2:0] ST_SB = 3'd5;
    localparam logic [2:0] ST_IB = 3'd6;

    typedef struct packed {
        logic [3:0] req_type;
        logic [7:0] line_index;
        logic       line_allocated;
        logic       put_dirty;
        logic       self_prefetch;
        logic [2:0] pending_type;
        logic       flush_success;
        logic       granted_modified;
    } req_t;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] down_msg;
        logic       down_dirty;
        logic       down_has_data;
        logic [1:0] up_msg;
        logic       up_success;
        logic       up_data_bypass;
        logic       line_write;
        logic [2:0] new_state;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    function automatic logic is_transient(logic [2:0] st);
        return (st == ST_IS) || (st == ST_IM) || (st == ST_SB) || (st == ST_IB);
    endfunction

endpackage

/* hw/rtl/wbcl_ctrl.sv */
`include "assert_macros.svh"

module wbcl_ctrl
    import wbcl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_reg;
    logic        done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy     = (state_reg == S_EXEC);
    assign done     = done_reg;
    assign cmd.load = start && (state_reg == S_IDLE);
    assign cmd.exec = (state_reg == S_EXEC);

    `ASSERT_NEXT(a_accept_runs, clk, rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_exec_one_cycle, clk, rst_n, busy, !busy && done)
    `ASSERT_IMPLY(a_done_not_busy, clk, rst_n, done, !busy)
    `ASSERT_IMPLY(a_done_after_exec, clk, rst_n, done, $past(busy))

endmodule

/* hw/rtl/wbcl_dp.sv */
module wbcl_dp
    import wbcl_pkg::*;
#(
    parameter int LINES = WBCL_LINES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  req_t                  req,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output rsp_t                  rsp
);

    localparam int DEPTH = (LINES < 256) ? LINES : 256;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [2:0]       state_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    req_t             req_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [2:0]       rd_state_reg;
    logic             rd_valid_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             writeback_clean_reg;
    logic             inclusive_reg;

    logic [7:0]       in_rem;
    logic [IDX_W-1:0] in_idx;

    // The line index is reduced modulo the line count by shifted subtraction.
    always_comb
    begin
        in_rem = req.line_index;
        for (int k = 7; k >= 0; k--)
        begin
            if (32'(in_rem) >= (32'(LINES) << k))
            begin
                in_rem = in_rem - 8'(32'(LINES) << k);
            end
        end
        in_idx = in_rem[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg      <= req;
            idx_reg      <= in_idx;
            rd_state_reg <= state_mem[in_idx];
            rd_valid_reg <= valid_reg[in_idx];
        end
        if (cmd.exec)
        begin
            state_mem[idx_reg] <= rsp_next.new_state;
            rsp_reg            <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg           <= '0;
            writeback_clean_reg <= 1'b0;
            inclusive_reg       <= 1'b1;
        end
        else
        begin
            if (cmd.exec)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WRITEBACK_CLEAN: writeback_clean_reg <= cfg_data[0];
                    CFG_INCLUSIVE:       inclusive_reg       <= cfg_data[0];
                    default:             ;
                endcase
            end
        end
    end

    always_comb
    begin
        logic [2:0] st_cur;
        logic [2:0] st;
        logic       alloc;
        logic       err;

        st_cur = rd_valid_reg ? rd_state_reg : ST_I;
        st     = st_cur;
        alloc  = req_reg.line_allocated;
        err    = 1'b0;

        rsp_next = '0;
        rsp_next.action   = ACT_DONE;
        rsp_next.down_msg = DOWN_NONE;
        rsp_next.up_msg   = UP_NONE;

        // For a put or flush request, a pending type moves an idle allocated line into its transient state.
        if ((req_reg.req_type >= REQ_PUTE) && (req_reg.req_type <= REQ_FLUSHINV) &&
            (req_reg.pending_type != PEND_NONE) && alloc && (st == ST_I))
        begin
            // Pending codes outside the defined set leave the line invalid.
            unique case (req_reg.pending_type)
                PEND_GETS:     st = ST_IS;
                PEND_GETX:     st = ST_IM;
                PEND_FLUSH:    st = ST_SB;
                PEND_FLUSHINV: st = ST_IB;
                default:       st = ST_I;
            endcase
        end

        unique case (req_reg.req_type)
            REQ_GETS, REQ_GETX, REQ_GETSEX:
            begin
                if (!alloc || is_transient(st))
                begin
                    err = 1'b1;
                end
                else if (st == ST_I)
                begin
                    priority if (req_reg.req_type == REQ_GETS)
                    begin
                        rsp_next.down_msg = DOWN_GETS;
                        st = ST_IS;
                    end
                    else if (req_reg.req_type == REQ_GETX)
                    begin
                        rsp_next.down_msg = DOWN_GETX;
                        st = ST_IM;
                    end
                    else
                    begin
                        rsp_next.down_msg = DOWN_GETSEX;
                        st = ST_IM;
                    end
                    rsp_next.action = ACT_STALL;
                end
                else if (req_reg.req_type == REQ_GETS)
                begin
                    if (!req_reg.self_prefetch)
                    begin
                        rsp_next.up_msg = UP_DATA_E;
                    end
                end
                else
                begin
                    rsp_next.up_msg = UP_DATA_M;
                end
            end
            REQ_PUTE, REQ_PUTM:
            begin
                if (!alloc)
                begin
                    err = 1'b1;
                end
                else if (st == ST_I)
                begin
                    rsp_next.line_write = 1'b1;
                    st = req_reg.put_dirty ? ST_M : ST_E;
                end
                else if (is_transient(st))
                begin
                    if (req_reg.put_dirty)
                    begin
                        rsp_next.action = ACT_BLOCK;
                    end
                end
                else if (req_reg.put_dirty)
                begin
                    rsp_next.line_write = 1'b1;
                    st = ST_M;
                end
            end
            REQ_FLUSH, REQ_FLUSHINV:
            begin
                rsp_next.action = ACT_STALL;
                if (req_reg.pending_type == PEND_NONE)
                begin
                    rsp_next.down_msg = (req_reg.req_type == REQ_FLUSH) ? DOWN_FLUSH
                                                                        : DOWN_FLUSHINV;
                    if (alloc)
                    begin
                        rsp_next.down_has_data = 1'b1;
                        rsp_next.down_dirty    = (st == ST_M);
                        if (req_reg.req_type == REQ_FLUSH)
                        begin
                            st = (st != ST_I) ? ST_SB : ST_IB;
                        end
                        else
                        begin
                            st = ST_IB;
                        end
                    end
                end
            end
            REQ_GETSRESP, REQ_GETXRESP:
            begin
                if (!inclusive_reg && (!alloc || (st == ST_I)))
                begin
                    rsp_next.up_msg = req_reg.granted_modified ? UP_DATA_M : UP_DATA_E;
                    rsp_next.up_data_bypass = 1'b1;
                end
                else if (!alloc)
                begin
                    err = 1'b1;
                end
                else if (st == ST_IS)
                begin
                    rsp_next.line_write = 1'b1;
                    st = ST_E;
                    if (!req_reg.self_prefetch)
                    begin
                        rsp_next.up_msg = UP_DATA_E;
                    end
                end
                else if (st == ST_IM)
                begin
                    rsp_next.line_write = 1'b1;
                    st = ST_M;
                    rsp_next.up_msg = UP_DATA_M;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            REQ_FLUSHRESP:
            begin
                if (alloc && (st == ST_SB))
                begin
                    st = ST_E;
                end
                else if (alloc && (st == ST_IB))
                begin
                    st = ST_I;
                end
                rsp_next.up_msg     = UP_FLUSH;
                rsp_next.up_success = req_reg.flush_success;
            end
            REQ_EVICT:
            begin
                if (!alloc)
                begin
                    err = 1'b1;
                end
                else if (st == ST_E)
                begin
                    if (writeback_clean_reg)
                    begin
                        rsp_next.down_msg      = DOWN_PUTE;
                        rsp_next.down_has_data = 1'b1;
                    end
                    st = ST_I;
                end
                else if (st == ST_M)
                begin
                    rsp_next.down_msg      = DOWN_PUTM;
                    rsp_next.down_dirty    = 1'b1;
                    rsp_next.down_has_data = 1'b1;
                    st = ST_I;
                end
                else if (is_transient(st))
                begin
                    rsp_next.action = ACT_STALL;
                end
            end
            default:
            begin
                err = 1'b1;
            end
        endcase

        if (err)
        begin
            rsp_next        = '0;
            rsp_next.action = ACT_ERROR;
            st              = st_cur;
        end
        rsp_next.new_state = st;
    end

    assign rsp = rsp_reg;

endmodule

/* hw/rtl/writeback_cache_line_state_controller_unit.sv */
// Line state controller for a write-back cache with I, E and M states and their
// transient forms. Raise start with an event on req while busy is low; the
// transaction is taken at that clock edge. The result appears on rsp after the
// next clock edge, held for exactly one cycle with done high, and the receiver
// cannot stall it, so it must capture rsp whenever done is set. A new event may
// be started in the same cycle that done shows, so the block sustains one event
// every two cycles: one cycle for the registered read of the line state memory
// and one for the update and its write back. Line states read as invalid after
// reset through per-line valid bits, so no clearing pass is needed. Write the
// configuration registers only while the block is idle.
module writeback_cache_line_state_controller_unit
    import wbcl_pkg::*;
#(
    parameter int LINES = WBCL_LINES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  req,
    output logic                  done,
    output rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;

    wbcl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    wbcl_dp #(
        .LINES (LINES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

endmodule
